@@ design/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_NORM = 3'd4;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_LOAD  = 4'd1,   // capture operands
    CMD_GCD   = 4'd2,   // start gcd of (x, y)
    CMD_DIV   = 4'd3,   // start divide of signed x by magnitude g
    CMD_MUL   = 4'd4,   // multiply x by y
    CMD_STEP  = 4'd5    // per-op sequencing step, selected by step index
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t  code;
    logic [4:0] step;
  } rau_cmd_t;

  typedef struct packed {
    logic busy;   // gcd or divide unit running
  } rau_stat_t;

endpackage

@@ design/rational_arithmetic_unit.sv @@
// Pass-through and divide by zero skip the serial unit; the other ops run it: each gcd
//   runs Euclid with one restoring pass per step (up to about 46 steps for 32-bit
//   words), each division by a gcd takes one more pass; arithmetic ops run two gcds
//   and four divisions.
// Throughput: one word at a time; the next word is taken after the result leaves.
// Reset (rst, synchronous): controller returns to idle, output word dropped.
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] res_num,
  output logic [31:0] res_den,
  output logic        invalid
);
  rau_pkg::rau_cmd_t  cmd;
  rau_pkg::rau_stat_t stat;
  logic [2:0] op_q;
  logic       zero_an, zero_ad, zero_bn;
  logic [2:0] op_r;

  // Hold the opcode for the whole operation.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= op;
    end
  end

  rau_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .op(op_q), .zero_an, .zero_ad, .zero_bn, .stat, .cmd
  );

  rau_datapath #(.W(WORD_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .op_in(op_r),
    .a_num_in(a_num), .a_den_in(a_den), .b_num_in(b_num), .b_den_in(b_den),
    .res_num, .res_den, .invalid, .op_q, .zero_an, .zero_ad, .zero_bn
  );
endmodule

@@ design/rau_datapath.sv @@
// Datapath: operand registers, iterative remainder/divide unit, multiplier.
module rau_datapath #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::rau_cmd_t cmd,
  output rau_pkg::rau_stat_t stat,
  input  logic [2:0]        op_in,
  input  logic [31:0]       a_num_in,
  input  logic [31:0]       a_den_in,
  input  logic [31:0]       b_num_in,
  input  logic [31:0]       b_den_in,
  output logic [31:0]       res_num,
  output logic [31:0]       res_den,
  output logic              invalid,
  output logic [2:0]        op_q,
  output logic              zero_an,
  output logic              zero_ad,
  output logic              zero_bn
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] an, ad, bn, bd, g, h, t0, t1, rn, rd;
  logic         bad;
  // Serial unit: restoring divide of magnitude num by magnitude den.
  logic [W-1:0] dq, drem, dden;
  logic [CW-1:0] dcnt;
  logic         drun;
  logic         gcd_mode, dneg;
  logic [W-1:0] gq;
  logic [W-1:0] qfin;

  function automatic logic [W-1:0] wext(input logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[W-1:0];
  endfunction

  function automatic logic [31:0] wout(input logic [W-1:0] v);
    logic [63:0] e;
    e = {{(64-W){v[W-1]}}, v};
    return e[31:0];
  endfunction

  function automatic logic [W-1:0] magw(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  assign qfin  = dneg ? (~dq + 1'b1) : dq;
  assign stat.busy = drun;
  assign op_q    = op_in;
  assign zero_an = (an == '0);
  assign zero_ad = (ad == '0);
  assign zero_bn = (bn == '0);
  assign res_num = wout(rn);
  assign res_den = wout(rd);
  assign invalid = bad;

  // Remainder of the restoring pass; needs drem with top bit kept.
  logic [W:0] shifted;
  assign shifted = {drem, dq[W-1]};
  logic [W:0] diff;
  assign diff = shifted - {1'b0, dden};

  always_ff @(posedge clk) begin
    if (rst) begin
      drun <= 1'b0;
      bad  <= 1'b0;
    end else begin
      if (drun) begin
        if (dcnt != '0) begin
          dcnt <= dcnt - 1'b1;
          if (!diff[W]) begin
            drem <= diff[W-1:0];
            dq   <= {dq[W-2:0], 1'b1};
          end else begin
            drem <= shifted[W-1:0];
            dq   <= {dq[W-2:0], 1'b0};
          end
        end else if (gcd_mode) begin
          // drem = gp mod gq; continue Euclid
          if (drem == '0) begin
            g    <= gq;
            drun <= 1'b0;
          end else begin
            gq   <= drem;
            dden <= drem;
            dq   <= gq;
            drem <= '0;
            dcnt <= CW'(W);
          end
        end else begin
          t0   <= qfin;
          drun <= 1'b0;
        end
      end
      case (cmd.code)
        rau_pkg::CMD_LOAD: begin
          an  <= wext(a_num_in);
          ad  <= wext(a_den_in);
          bn  <= wext(b_num_in);
          bd  <= wext(b_den_in);
          bad <= 1'b0;
        end
        rau_pkg::CMD_GCD: begin
          // t0, t1 hold the arguments
          gcd_mode <= 1'b1;
          if (magw(t1) == '0) begin
            g <= magw(t0);
          end else begin
            gq   <= magw(t1);
            dden <= magw(t1);
            dq   <= magw(t0);
            drem <= '0;
            dcnt <= CW'(W);
            drun <= 1'b1;
          end
        end
        rau_pkg::CMD_DIV: begin
          // t0 divided by g; zero g leaves t0
          gcd_mode <= 1'b0;
          if (g != '0) begin
            dneg <= t0[W-1];
            dq   <= magw(t0);
            dden <= g;
            drem <= '0;
            dcnt <= CW'(W);
            drun <= 1'b1;
          end
        end
        rau_pkg::CMD_MUL: t0 <= W'(t0 * t1);
        rau_pkg::CMD_STEP: begin
          case (cmd.step)
            5'd0:  begin t0 <= ad; t1 <= bd; end              // gcd(ad,bd)
            5'd1:  begin h <= g; t0 <= ad; end                 // den = ad/g
            5'd2:  begin rd <= t0; t0 <= bd; end               // bd/g
            5'd3:  begin t1 <= an; end                         // an*(bd/g)
            5'd4:  begin rn <= t0; t0 <= bn; t1 <= rd; end     // bn*den
            5'd5:  begin
              t0 <= (op_in == rau_pkg::OP_SUB) ? rn - t0 : rn + t0;
              t1 <= h;
              rn <= (op_in == rau_pkg::OP_SUB) ? rn - t0 : rn + t0;
            end
            5'd6:  begin h <= g; t0 <= rn; end                 // num/h
            5'd7:  begin rn <= t0; t0 <= bd; g <= h; end       // bd/h
            5'd8:  begin t1 <= rd; end                         // den*(bd/h)
            5'd9:  begin rd <= t0; end
            // divide: reciprocal of b, sign to numerator
            5'd10: begin
              if (bn[W-1]) begin
                t0 <= ~bd + 1'b1;
                bd <= ~bn + 1'b1;
                bn <= ~bd + 1'b1;
              end else begin
                bn <= bd;
                bd <= bn;
              end
            end
            // multiply: g1 = gcd(an,bd)
            5'd11: begin t0 <= an; t1 <= bd; end
            5'd12: begin h <= g; t0 <= bn; t1 <= ad; end       // g2
            5'd13: begin t0 <= an; g <= h; t1 <= g; end        // an/g1 (t1=g2)
            5'd14: begin rn <= t0; t0 <= bn; g <= t1; end      // bn/g2
            5'd15: begin t1 <= rn; end                         // product
            5'd16: begin rn <= t0; t0 <= ad; end               // ad/g2
            5'd17: begin rd <= t0; t0 <= bd; g <= h; end       // bd/g1
            5'd18: begin t1 <= rd; end
            5'd19: begin rd <= t0; end
            // normalize
            5'd20: begin rn <= an; rd <= ad; t0 <= an; t1 <= ad; end
            5'd21: begin rd <= {{(W-1){1'b0}}, 1'b1}; end
            5'd22: begin t0 <= an; end                         // an/g
            5'd23: begin rn <= t0; t0 <= ad; end               // ad/g
            5'd24: begin
              if (t0[W-1]) begin
                rn <= ~rn + 1'b1;
                rd <= ~t0 + 1'b1;
              end else begin
                rd <= t0;
              end
            end
            5'd25: begin
              rn  <= {1'b1, {(W-1){1'b0}}};
              rd  <= {1'b1, {(W-1){1'b0}}};
              bad <= 1'b1;
            end
            5'd26: begin rn <= an; rd <= ad; end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end
endmodule

@@ design/rau_ctrl.sv @@
// Controller: sequences datapath commands for each operation.
module rau_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         op,
  input  logic               zero_an,
  input  logic               zero_ad,
  input  logic               zero_bn,
  input  rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_cmd_t  cmd
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT = 5'b00100,
    S_DONE = 5'b01000,
    S_OUT = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [5:0] pc, pc_next;
  rau_pkg::rau_cmd_t prog;
  logic       last;

  localparam logic [5:0] PC_ADD  = 6'd0;
  localparam logic [5:0] PC_DIV  = 6'd20;
  localparam logic [5:0] PC_MUL  = 6'd23;
  localparam logic [5:0] PC_NORM = 6'd40;
  localparam logic [5:0] PC_BAD  = 6'd50;
  localparam logic [5:0] PC_NOP  = 6'd51;
  localparam logic [5:0] PC_ZN   = 6'd52;

  function automatic rau_pkg::rau_cmd_t mk(input rau_pkg::cmd_code_t c,
                                          input logic [4:0] s);
    rau_pkg::rau_cmd_t r;
    r.code = c;
    r.step = s;
    return r;
  endfunction

  // Microprogram; last marks end of sequence.
  always_comb begin
    last = 1'b0;
    prog = mk(rau_pkg::CMD_NONE, 5'd0);
    case (pc)
      6'd0:  prog = mk(rau_pkg::CMD_STEP, 5'd0);
      6'd1:  prog = mk(rau_pkg::CMD_GCD, 5'd0);
      6'd2:  prog = mk(rau_pkg::CMD_STEP, 5'd1);
      6'd3:  prog = mk(rau_pkg::CMD_DIV, 5'd0);
      6'd4:  prog = mk(rau_pkg::CMD_STEP, 5'd2);
      6'd5:  prog = mk(rau_pkg::CMD_DIV, 5'd0);
      6'd6:  prog = mk(rau_pkg::CMD_STEP, 5'd3);
      6'd7:  prog = mk(rau_pkg::CMD_MUL, 5'd0);
      6'd8:  prog = mk(rau_pkg::CMD_STEP, 5'd4);
      6'd9:  prog = mk(rau_pkg::CMD_MUL, 5'd0);
      6'd10: prog = mk(rau_pkg::CMD_STEP, 5'd5);
      6'd11: prog = mk(rau_pkg::CMD_GCD, 5'd0);
      6'd12: prog = mk(rau_pkg::CMD_STEP, 5'd6);
      6'd13: prog = mk(rau_pkg::CMD_DIV, 5'd0);
      6'd14: prog = mk(rau_pkg::CMD_STEP, 5'd7);
      6'd15: prog = mk(rau_pkg::CMD_DIV, 5'd0);
      6'd16: prog = mk(rau_pkg::CMD_STEP, 5'd8);
      6'd17: prog = mk(rau_pkg::CMD_MUL, 5'd0);
      6'd18: begin prog = mk(rau_pkg::CMD_STEP, 5'd9); last = 1'b1; end
      6'd20: prog = mk(rau_pkg::CMD_STEP, 5'd10);
      6'd23: prog = mk(rau_pkg::CMD_STEP, 5'd11);
      6'd24: prog = mk(rau_pkg::CMD_GCD, 5'd0);
      6'd25: prog = mk(rau_pkg::CMD_STEP, 5'd12);
      6'd26: prog = mk(rau_pkg::CMD_GCD, 5'd0);
      6'd27: prog = mk(rau_pkg::CMD_STEP, 5'd13);
      6'd28: prog = mk(rau_pkg::CMD_DIV, 5'd0);
      6'd29: prog = mk(rau_pkg::CMD_STEP, 5'd14);
      6'd30: prog = mk(rau_pkg::CMD_DIV, 5'd0);
      6'd31: prog = mk(rau_pkg::CMD_STEP, 5'd15);
      6'd32: prog = mk(rau_pkg::CMD_MUL, 5'd0);
      6'd33: prog = mk(rau_pkg::CMD_STEP, 5'd16);
      6'd34: prog = mk(rau_pkg::CMD_DIV, 5'd0);
      6'd35: prog = mk(rau_pkg::CMD_STEP, 5'd17);
      6'd36: prog = mk(rau_pkg::CMD_DIV, 5'd0);
      6'd37: prog = mk(rau_pkg::CMD_STEP, 5'd18);
      6'd38: prog = mk(rau_pkg::CMD_MUL, 5'd0);
      6'd39: begin prog = mk(rau_pkg::CMD_STEP, 5'd19); last = 1'b1; end
      6'd40: prog = mk(rau_pkg::CMD_STEP, 5'd20);
      6'd41: prog = mk(rau_pkg::CMD_GCD, 5'd0);
      6'd42: prog = mk(rau_pkg::CMD_STEP, 5'd22);
      6'd43: prog = mk(rau_pkg::CMD_DIV, 5'd0);
      6'd44: prog = mk(rau_pkg::CMD_STEP, 5'd23);
      6'd45: prog = mk(rau_pkg::CMD_DIV, 5'd0);
      6'd46: begin prog = mk(rau_pkg::CMD_STEP, 5'd24); last = 1'b1; end
      6'd50: begin prog = mk(rau_pkg::CMD_STEP, 5'd25); last = 1'b1; end
      6'd51: begin prog = mk(rau_pkg::CMD_STEP, 5'd26); last = 1'b1; end
      6'd52: prog = mk(rau_pkg::CMD_STEP, 5'd20);
      6'd53: begin prog = mk(rau_pkg::CMD_STEP, 5'd21); last = 1'b1; end
      default: last = 1'b1;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    pc_next    = pc;
    cmd        = mk(rau_pkg::CMD_NONE, 5'd0);
    case (state)
      S_IDLE: if (in_valid) begin
        cmd        = mk(rau_pkg::CMD_LOAD, 5'd0);
        state_next = S_DONE;
      end
      S_DONE: begin
        // choose the sequence now that operands are registered
        state_next = S_ISSUE;
        case (op)
          rau_pkg::OP_ADD, rau_pkg::OP_SUB: pc_next = PC_ADD;
          rau_pkg::OP_MUL:  pc_next = PC_MUL;
          rau_pkg::OP_DIV:  pc_next = zero_bn ? PC_BAD : PC_DIV;
          rau_pkg::OP_NORM: pc_next = zero_ad ? PC_NOP
                                    : (zero_an ? PC_ZN : PC_NORM);
          default:          pc_next = PC_NOP;
        endcase
      end
      S_ISSUE: begin
        cmd = prog;
        if (last) begin
          state_next = S_OUT;
        end else if (pc == 6'd20) begin
          pc_next = PC_MUL;
        end else if (pc == PC_ZN) begin
          pc_next = 6'd53;
          state_next = S_ISSUE;
        end else begin
          pc_next = pc + 1'b1;
          if (prog.code == rau_pkg::CMD_GCD || prog.code == rau_pkg::CMD_DIV) begin
            state_next = S_WAIT;
          end
        end
        if (pc == PC_ZN) begin
          state_next = S_ISSUE;
        end
      end
      S_WAIT: if (!stat.busy) begin
        state_next = S_ISSUE;
      end
      S_OUT: if (out_ready) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end
endmodule
